// File: rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, quiet while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication check: antecedent must be followed by consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst, (ante) |-> (cons), msg)

`endif

// File: rtl/mpt_pkg.sv
`timescale 1ns / 1ps

package mpt_pkg;

  // width of the packed level beat
  localparam int unsigned OUT_W = 12;

  // action codes of the input beat
  typedef enum logic [1:0] {
    ACT_TICK       = 2'd0,
    ACT_SET_PERIOD = 2'd1,
    ACT_STOP       = 2'd2,
    ACT_SET_LEVEL  = 2'd3
  } act_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_APPLY = 2'd1,
    ST_TICK  = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;     // capture the input beat
    logic apply;     // carry out a non-tick action
    logic tick_step; // advance one channel of a tick
    logic load_out;  // copy the levels into the output register
  } cmd_t;

endpackage

// File: rtl/mpt_ctrl.sv
`timescale 1ns / 1ps

module mpt_ctrl #(
  parameter int unsigned CHANNELS = 12,
  parameter int unsigned IDX_W    = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mpt_pkg::cmd_t        cmd,
  output logic [IDX_W-1:0]     walk_idx,
  output mpt_pkg::state_t      state
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  mpt_pkg::state_t  state_next;
  logic [IDX_W-1:0] walk_idx_next;
  logic             out_valid_next;
  logic             accept;
  logic             out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // state, walk counter and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mpt_pkg::ST_IDLE;
      walk_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      walk_idx  <= walk_idx_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mpt_pkg::ST_IDLE: begin
        if (accept) begin
          if (action == mpt_pkg::ACT_TICK) state_next = mpt_pkg::ST_TICK;
          else state_next = mpt_pkg::ST_APPLY;
        end
      end
      mpt_pkg::ST_APPLY: state_next = mpt_pkg::ST_DONE;
      mpt_pkg::ST_TICK: begin
        if (walk_idx == LAST_IDX) state_next = mpt_pkg::ST_DONE;
      end
      mpt_pkg::ST_DONE: begin
        if (out_free) state_next = mpt_pkg::ST_IDLE;
      end
      default: state_next = mpt_pkg::ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    walk_idx_next  = walk_idx;
    out_valid_next = out_valid && !out_ready;
    case (state)
      mpt_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = accept;
      end
      mpt_pkg::ST_APPLY: cmd.apply = 1'b1;
      mpt_pkg::ST_TICK: begin
        cmd.tick_step = 1'b1;
        if (walk_idx == LAST_IDX) walk_idx_next = '0;
        else walk_idx_next = walk_idx + 1'b1;
      end
      mpt_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        walk_idx_next = '0;
      end
    endcase
  end

endmodule

// File: rtl/mpt_dp.sv
`timescale 1ns / 1ps

module mpt_dp #(
  parameter int unsigned CHANNELS = 12,
  parameter int unsigned ON_TIME  = 6,
  parameter int unsigned IDX_W    = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mpt_pkg::cmd_t               cmd,
  input  logic [IDX_W-1:0]            walk_idx,
  input  logic [1:0]                  action,
  input  logic [3:0]                  channel,
  input  logic [7:0]                  period_value,
  input  logic                        level,
  output logic [mpt_pkg::OUT_W-1:0]   output_bits
);

  localparam logic [7:0] ON_T     = 8'(ON_TIME);
  localparam logic [7:0] ON_T_P1  = 8'(ON_TIME + 1);
  localparam logic [5:0] CH_LIMIT = 6'(CHANNELS);

  // per-channel state
  logic [7:0]          periods    [CHANNELS];
  logic [7:0]          countdowns [CHANNELS];
  logic [CHANNELS-1:0] levels;

  // latched input beat
  mpt_pkg::act_t act_q;
  logic [3:0]    chan_q;
  logic [7:0]    pv_q;
  logic          lv_q;

  logic             ch_ok;
  logic [IDX_W-1:0] ch_idx;
  logic [7:0]       pv_clamped;
  logic [7:0]       cd_cur;
  logic [7:0]       per_cur;
  logic [7:0]       cd_dec;
  logic             step_live;
  logic [7:0]       cd_new;
  logic             lv_new;
  logic [mpt_pkg::OUT_W-1:0] packed_levels;

  // channel range check and period clamp
  assign ch_ok      = 6'(chan_q) < CH_LIMIT;
  assign ch_idx     = IDX_W'(chan_q);
  assign pv_clamped = (pv_q != 8'd0 && pv_q <= ON_T) ? ON_T_P1 : pv_q;

  // one channel of a tick
  always_comb begin
    cd_cur    = countdowns[walk_idx];
    per_cur   = periods[walk_idx];
    step_live = (cd_cur != 8'd0) || (per_cur != 8'd0);
    cd_dec    = ((cd_cur == 8'd0) ? per_cur : cd_cur) - 8'd1;
    cd_new    = cd_dec;
    lv_new    = levels[walk_idx];
    if (cd_dec == 8'd0) begin
      if (levels[walk_idx]) begin
        lv_new = 1'b0;
        cd_new = (per_cur > ON_T) ? per_cur - ON_T : 8'd0;
      end else begin
        lv_new = 1'b1;
        cd_new = ON_T;
      end
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q  <= mpt_pkg::act_t'(action);
      chan_q <= channel;
      pv_q   <= period_value;
      lv_q   <= level;
    end
  end

  // channel state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        periods[i]    <= 8'd0;
        countdowns[i] <= 8'd0;
      end
      levels <= '0;
    end else if (cmd.tick_step) begin
      if (step_live) begin
        countdowns[walk_idx] <= cd_new;
        levels[walk_idx]     <= lv_new;
      end
    end else if (cmd.apply) begin
      case (act_q)
        mpt_pkg::ACT_SET_PERIOD: begin
          if (ch_ok) periods[ch_idx] <= pv_clamped;
        end
        mpt_pkg::ACT_STOP: begin
          for (int i = 0; i < CHANNELS; i++) periods[i] <= 8'd0;
        end
        mpt_pkg::ACT_SET_LEVEL: begin
          if (ch_ok) levels[ch_idx] <= lv_q;
        end
        default: ;
      endcase
    end
  end

  // pack the first twelve channels, zero above CHANNELS
  for (genvar b = 0; b < mpt_pkg::OUT_W; b++) begin : g_pack
    if (b < CHANNELS) begin : g_used
      assign packed_levels[b] = levels[b];
    end else begin : g_unused
      assign packed_levels[b] = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) output_bits <= packed_levels;
  end

endmodule

// File: rtl/multichannel_pulse_train_timer.sv
`timescale 1ns / 1ps
// Multichannel pulse train timer.
// Input channel (in_valid/in_ready): one beat carries action, channel,
// period_value and level. Actions are tick, set period, stop all and set level.
// Output channel (out_valid/out_ready): exactly one beat per input beat,
// output_bits holding the level of channels 0..11 after the action.
// A tick walks the channels one per cycle through a single update unit,
// then passes through the done state, which loads the result into the
// output register and reopens the input; every other action passes through
// the apply state and then the done state in the same way.
// The next beat is taken while a finished result still waits in the output
// register; a stalled receiver holds the block only once a further result is
// ready to be loaded, and the waiting result stays unchanged until taken.
// Reset (rst, synchronous) clears all periods, counters and levels and empties
// the output register; the block accepts a beat in the first cycle after it.
`include "assert_macros.svh"

module multichannel_pulse_train_timer #(
  parameter int unsigned CHANNELS = 12,
  parameter int unsigned ON_TIME  = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                action,
  input  logic [3:0]                channel,
  input  logic [7:0]                period_value,
  input  logic                      level,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mpt_pkg::OUT_W-1:0] output_bits
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  mpt_pkg::cmd_t    cmd;
  mpt_pkg::state_t  state;
  logic [IDX_W-1:0] walk_idx;

  // sequencing
  mpt_ctrl #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .walk_idx  (walk_idx),
    .state     (state)
  );

  // channel state and output register
  mpt_dp #(
    .CHANNELS (CHANNELS),
    .ON_TIME  (ON_TIME),
    .IDX_W    (IDX_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .walk_idx     (walk_idx),
    .action       (action),
    .channel      (channel),
    .period_value (period_value),
    .level        (level),
    .output_bits  (output_bits)
  );

  // checks
  `ASSERT_CLK(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready, "input taken while busy")
  `ASSERT_CLK(a_valid_from_done, clk, rst, $rose(out_valid) |-> ($past(state) == mpt_pkg::ST_DONE), "result raised outside done")
  `ASSERT_IMPL(a_walk_idle_zero, clk, rst, state == mpt_pkg::ST_IDLE, walk_idx == '0, "walk counter not rewound")

endmodule

// File: verif/multichannel_pulse_train_timer_tb.sv
`timescale 1ns / 1ps

module multichannel_pulse_train_timer_tb;

  localparam int unsigned CHANNELS    = 12;
  localparam int unsigned ON_TIME     = 6;
  localparam int unsigned RANDOM_BEATS = 1450;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LIMIT       = 400000;

  // level model and store of predicted output words
  class level_scoreboard;
    logic [7:0]       period_q [CHANNELS];
    logic [7:0]       count_q  [CHANNELS];
    logic             level_q  [CHANNELS];
    logic [mpt_pkg::OUT_W-1:0] pending_bits [$];
    logic [mpt_pkg::OUT_W-1:0] last_bits;
    int mismatches;
    int results_seen;
    int n_ticks, n_periods, n_stops, n_levels, n_ignored, rises;

    function new();
      for (int i = 0; i < CHANNELS; i++) begin
        period_q[i] = '0;
        count_q[i]  = '0;
        level_q[i]  = 1'b0;
      end
      last_bits = '0;
      mismatches = 0;
      results_seen = 0;
      n_ticks = 0; n_periods = 0; n_stops = 0; n_levels = 0; n_ignored = 0; rises = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // one tick walks every channel
    function void run_tick();
      for (int i = 0; i < CHANNELS; i++) begin
        if (count_q[i] == 8'd0) begin
          if (period_q[i] == 8'd0) continue;
          count_q[i] = period_q[i];
        end
        count_q[i] = count_q[i] - 8'd1;
        if (count_q[i] == 8'd0) begin
          if (level_q[i]) begin
            level_q[i] = 1'b0;
            count_q[i] = (period_q[i] > ON_TIME) ? period_q[i] - 8'(ON_TIME) : 8'd0;
          end else begin
            level_q[i] = 1'b1;
            count_q[i] = 8'(ON_TIME);
          end
        end
      end
    endfunction

    function logic [mpt_pkg::OUT_W-1:0] packed_levels();
      logic [mpt_pkg::OUT_W-1:0] bits;
      bits = '0;
      for (int i = 0; i < CHANNELS && i < mpt_pkg::OUT_W; i++) bits[i] = level_q[i];
      return bits;
    endfunction

    // accepted input beat: update the model and queue the level word
    function void note_beat(mpt_pkg::act_t act, logic [3:0] ch, logic [7:0] pv, logic lv);
      logic [7:0] p;
      case (act)
        mpt_pkg::ACT_TICK: begin
          n_ticks++;
          run_tick();
        end
        mpt_pkg::ACT_SET_PERIOD: begin
          n_periods++;
          if (ch < CHANNELS) begin
            p = pv;
            if (p != 8'd0 && p <= ON_TIME) p = 8'(ON_TIME + 1);
            period_q[ch] = p;
          end else begin
            n_ignored++;
          end
        end
        mpt_pkg::ACT_STOP: begin
          n_stops++;
          for (int i = 0; i < CHANNELS; i++) period_q[i] = 8'd0;
        end
        default: begin
          n_levels++;
          if (ch < CHANNELS) level_q[ch] = lv;
          else n_ignored++;
        end
      endcase
      pending_bits.push_back(packed_levels());
    endfunction

    // accepted output beat against the oldest prediction
    task check_result(logic [mpt_pkg::OUT_W-1:0] got);
      logic [mpt_pkg::OUT_W-1:0] want;
      if (pending_bits.size() == 0) begin
        report($sformatf("output beat 0x%03h with nothing outstanding", got));
        return;
      end
      want = pending_bits.pop_front();
      results_seen++;
      if (got !== want)
        report($sformatf("result %0d: output_bits 0x%03h, predicted 0x%03h",
                         results_seen, got, want));
      rises += $countones(got & ~last_bits);
      last_bits = got;
    endtask

    function int pending_count();
      return pending_bits.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                action;
  logic [3:0]                channel;
  logic [7:0]                period_value;
  logic                      level;
  logic                      out_valid;
  logic                      out_ready;
  logic [mpt_pkg::OUT_W-1:0] output_bits;

  level_scoreboard sb = new();

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;
  int beats_sent = 0;
  int cycle_count = 0;

  multichannel_pulse_train_timer #(
    .CHANNELS(CHANNELS),
    .ON_TIME (ON_TIME)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .channel     (channel),
    .period_value(period_value),
    .level       (level),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .output_bits (output_bits)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run limit of %0d cycles reached", LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // offer one input beat, optionally after a random gap, and wait for it to be taken
  task send_beat(mpt_pkg::act_t act, logic [3:0] ch, logic [7:0] pv, logic lv);
    int gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    channel      <= ch;
    period_value <= pv;
    level        <= lv;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(act, ch, pv, lv);
    beats_sent++;
  endtask

  // run of ticks with junk on the unused fields
  task tick_run(int n);
    repeat (n) send_beat(mpt_pkg::ACT_TICK, 4'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // mostly short periods so that trains complete, now and then the full range
  function logic [7:0] rand_period();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1, 2:    return 8'($urandom_range(1, ON_TIME + 1));
      3:       return 8'($urandom);
      default: return 8'($urandom_range(ON_TIME + 1, 24));
    endcase
  endfunction

  function logic [3:0] rand_channel();
    return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(CHANNELS, 15))
                                       : 4'($urandom_range(0, CHANNELS - 1));
  endfunction

  // receiver: random stall before each beat while rx_idle is set, one long hold-off on request
  initial begin
    int stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 18) : 0;
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(output_bits);
    end
  end

  // stimulus
  initial begin
    int total;
    int next_segment;
    bit hold_done;
    int n;
    in_valid     <= 1'b0;
    action       <= mpt_pkg::ACT_TICK;
    channel      <= '0;
    period_value <= '0;
    level        <= 1'b0;
    out_ready    <= 1'b0;
    rst          <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: idle tick, level writes in and out of range
    send_beat(mpt_pkg::ACT_TICK, 4'd0, 8'd0, 1'b0);
    send_beat(mpt_pkg::ACT_SET_LEVEL, 4'd0, 8'd0, 1'b1);
    send_beat(mpt_pkg::ACT_SET_LEVEL, 4'd11, 8'hff, 1'b1);
    send_beat(mpt_pkg::ACT_SET_LEVEL, 4'd12, 8'd0, 1'b1);
    send_beat(mpt_pkg::ACT_SET_LEVEL, 4'd15, 8'hff, 1'b1);
    // period writes: disable, clamp edges, extremes, ignored channels
    send_beat(mpt_pkg::ACT_SET_PERIOD, 4'd0, 8'd0, 1'b1);
    send_beat(mpt_pkg::ACT_SET_PERIOD, 4'd1, 8'd1, 1'b0);
    send_beat(mpt_pkg::ACT_SET_PERIOD, 4'd2, 8'(ON_TIME), 1'b0);
    send_beat(mpt_pkg::ACT_SET_PERIOD, 4'd3, 8'(ON_TIME + 1), 1'b1);
    send_beat(mpt_pkg::ACT_SET_PERIOD, 4'd4, 8'hff, 1'b0);
    send_beat(mpt_pkg::ACT_SET_PERIOD, 4'd11, 8'd8, 1'b0);
    send_beat(mpt_pkg::ACT_SET_PERIOD, 4'd13, 8'd100, 1'b1);
    send_beat(mpt_pkg::ACT_SET_PERIOD, 4'd15, 8'hff, 1'b1);
    tick_run(8);
    send_beat(mpt_pkg::ACT_SET_LEVEL, 4'd3, 8'h55, 1'b0);
    send_beat(mpt_pkg::ACT_TICK, 4'd15, 8'hff, 1'b1);
    // stop while pulses are running: on outputs reach zero with no period
    send_beat(mpt_pkg::ACT_STOP, 4'd9, 8'haa, 1'b1);
    tick_run(4);

    // random sequences
    total = beats_sent + RANDOM_BEATS;
    next_segment = beats_sent;
    hold_done = 1'b0;
    while (beats_sent < total) begin
      if (beats_sent >= next_segment) begin
        tx_idle = ($urandom_range(0, 9) < 7);
        rx_idle = ($urandom_range(0, 9) < 7);
        next_segment += 100;
      end
      if (!hold_done && beats_sent >= total - RANDOM_BEATS + 600) begin
        tx_idle   = 1'b0;
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      case ($urandom_range(0, 19))
        // pulse train: a few period writes then a run of ticks
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          n = $urandom_range(1, 3);
          repeat (n)
            send_beat(mpt_pkg::ACT_SET_PERIOD, rand_channel(), rand_period(),
                      1'($urandom));
          tick_run($urandom_range(10, 60));
        end
        10, 11, 12:
          send_beat(mpt_pkg::ACT_SET_LEVEL, rand_channel(), 8'($urandom), 1'($urandom));
        13, 14: begin
          send_beat(mpt_pkg::ACT_STOP, 4'($urandom), 8'($urandom), 1'($urandom));
          tick_run($urandom_range(5, 30));
        end
        default:
          send_beat(mpt_pkg::act_t'($urandom_range(0, 3)), 4'($urandom), 8'($urandom),
                    1'($urandom));
      endcase
    end
    in_valid <= 1'b0;

    // drain and let the tail run out
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (CHANNELS + 8) @(posedge clk);
    if (sb.pending_count() != 0)
      sb.report($sformatf("%0d predicted beats never delivered", sb.pending_count()));
    $display("%0d beats: %0d ticks, %0d period writes, %0d stops, %0d level writes",
             beats_sent, sb.n_ticks, sb.n_periods, sb.n_stops, sb.n_levels);
    $display("%0d results checked, %0d out-of-range writes, %0d output rises, %0d cycles",
             sb.results_seen, sb.n_ignored, sb.rises, cycle_count);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: multichannel_pulse_train_timer.f
+incdir+rtl
rtl/mpt_pkg.sv
rtl/mpt_ctrl.sv
rtl/mpt_dp.sv
rtl/multichannel_pulse_train_timer.sv
verif/multichannel_pulse_train_timer_tb.sv
